// ----- sv/dss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the dual stack block.
// No dependencies; dss_ctrl and dual_stack_shared_memory import this package.
package dss_pkg;

  localparam int WORD_W = 32;

  // Request codes
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_DISPLAY = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     which_stack;
    logic signed [WORD_W-1:0] push_value;
  } dss_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_out;
    logic                     last;
  } dss_result_t;

  // One result issued by the controller; data comes from the RAM when use_ram is set
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       last;
    logic       use_ram;
  } dss_issue_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } dss_state_t;

endpackage

// ----- sv/dss_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload of type T.
// Used with payload types from dss_pkg.
interface dss_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- sv/dss_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dss_ctrl.sv -----
`timescale 1ns / 1ps
// Request controller: stack counts, address generation and display sequencer.
// Depends on dss_pkg; drives the ports of the shared RAM.
module dss_ctrl #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dss_pkg::dss_req_t           req_data,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        can_issue,
  output dss_pkg::dss_issue_t         issue,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [dss_pkg::WORD_W-1:0]  wr_data,
  output logic [$clog2(DEPTH)-1:0]    rd_addr
);
  import dss_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  dss_state_t        state, state_next;
  logic [CNT_W-1:0]  lower_count;
  logic [CNT_W-1:0]  upper_count;
  logic [ADDR_W-1:0] list_addr;
  logic [CNT_W-1:0]  list_rem;
  logic              list_upper;

  logic              accept;
  logic [CNT_W-1:0]  sel_count;
  logic [CNT_W:0]    used;
  logic              full;
  logic [CNT_W-1:0]  upper_top;
  logic [CNT_W-1:0]  lower_top;
  logic [CNT_W-1:0]  upper_free;
  logic [ADDR_W-1:0] top_addr;
  logic              push_ok;
  logic              pop_ok;
  logic              list_start;
  logic              list_issue;

  assign sel_count  = req_data.which_stack ? upper_count : lower_count;
  assign used       = {1'b0, lower_count} + {1'b0, upper_count};
  assign full       = used >= {1'b0, DEPTH_C};
  assign upper_top  = DEPTH_C - upper_count;
  assign lower_top  = lower_count - ONE_C;
  assign upper_free = DEPTH_C - upper_count - ONE_C;
  assign top_addr   = req_data.which_stack ? upper_top[ADDR_W-1:0] : lower_top[ADDR_W-1:0];

  assign req_ready  = (state == S_IDLE) && can_issue;
  assign accept     = req_valid && req_ready;
  assign push_ok    = accept && (req_data.req_type == REQ_PUSH) && !full;
  assign pop_ok     = accept && (req_data.req_type == REQ_POP) && (sel_count != '0);
  assign list_start = accept && (req_data.req_type == REQ_DISPLAY) && (sel_count > ONE_C);
  assign list_issue = (state == S_LIST) && can_issue;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (list_start) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (list_issue && (list_rem == ONE_C)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    issue   = '0;
    wr_en   = 1'b0;
    wr_addr = req_data.which_stack ? upper_free[ADDR_W-1:0] : lower_count[ADDR_W-1:0];
    wr_data = req_data.push_value;
    rd_addr = top_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_data.req_type)
            REQ_PUSH: begin
              issue.valid  = 1'b1;
              issue.status = full ? ST_OVERFLOW : ST_OK;
              issue.last   = 1'b1;
              wr_en        = !full;
            end
            REQ_POP, REQ_DISPLAY: begin
              issue.valid   = 1'b1;
              issue.status  = (sel_count == '0) ? ST_UNDERFLOW : ST_OK;
              issue.use_ram = (sel_count != '0);
              issue.last    = (req_data.req_type == REQ_POP) || (sel_count <= ONE_C);
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        rd_addr = list_addr;
        if (can_issue) begin
          issue.valid   = 1'b1;
          issue.status  = ST_OK;
          issue.use_ram = 1'b1;
          issue.last    = (list_rem == ONE_C);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lower_count <= '0;
      upper_count <= '0;
    end else begin
      state <= state_next;
      if (push_ok) begin
        if (req_data.which_stack) upper_count <= upper_count + ONE_C;
        else                      lower_count <= lower_count + ONE_C;
      end else if (pop_ok) begin
        if (req_data.which_stack) upper_count <= upper_count - ONE_C;
        else                      lower_count <= lower_count - ONE_C;
      end
    end
  end

  // Display walk: upper stack moves toward the top of the store, lower toward word 0
  always_ff @(posedge clk) begin
    if (list_start) begin
      list_rem   <= sel_count - ONE_C;
      list_upper <= req_data.which_stack;
      list_addr  <= req_data.which_stack ? top_addr + ADDR_W'(1) : top_addr - ADDR_W'(1);
    end else if (list_issue) begin
      list_rem  <= list_rem - ONE_C;
      list_addr <= list_upper ? list_addr + ADDR_W'(1) : list_addr - ADDR_W'(1);
    end
  end

endmodule

// ----- sv/dual_stack_shared_memory.sv -----
`timescale 1ns / 1ps
// Top level of the dual stack block: controller, shared RAM and result queue.
// Depends on dss_pkg, dss_stream_if, dss_ram and dss_ctrl.
//
// Two LIFO stacks share one RAM of DEPTH words; the lower grows up from word 0,
// the upper grows down from word DEPTH-1.
// Channels: req (sink) carries dss_req_t transactions, rsp (source) carries
// dss_result_t transactions. Both are valid/ready; a transaction moves at a
// rising edge with valid and ready high.
// A result passes through the RAM read stage, which registers the read data
// and the pend_* tag at the edge that takes its request, and then the result
// queue, which drives rsp.
// Push and pop do not hold req.ready low; a display of N words holds
// req.ready low while the sequencer walks the RAM, one word per cycle while
// the result queue has room. Request code 3 is taken and produces no result.
// The two-entry result queue plus the RAM read stage set the credit: when rsp
// stalls, the queue fills and req.ready (and the display walk) stops until a
// result is taken. No result is dropped or repeated.
// Reset (rst, synchronous) empties both stacks and the result queue; RAM
// contents are not cleared and need no clearing pass.
module dual_stack_shared_memory #(
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  dss_stream_if.sink   req,
  dss_stream_if.source rsp
);
  import dss_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  dss_issue_t        issue;
  logic              can_issue;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  // Read stage
  logic              pend_valid;
  logic [1:0]        pend_status;
  logic              pend_last;
  logic              pend_use_ram;

  // Result queue
  dss_result_t       q_mem [2];
  logic              q_head;
  logic [1:0]        q_count;
  logic [1:0]        occ;
  logic              out_fire;
  logic              q_tail;
  dss_result_t       pend_result;

  dss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .can_issue (can_issue),
    .issue     (issue),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr)
  );

  dss_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rsp.valid = (q_count != 2'd0);
  assign rsp.data  = q_mem[q_head];
  assign out_fire  = rsp.valid && rsp.ready;
  assign occ       = q_count + {1'b0, pend_valid};
  assign can_issue = (occ < 2'd2) || out_fire;
  assign q_tail    = q_head ^ q_count[0];

  always_comb begin
    pend_result.status   = pend_status;
    pend_result.data_out = pend_use_ram ? rd_data : '0;
    pend_result.last     = pend_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      q_head     <= 1'b0;
      q_count    <= 2'd0;
    end else begin
      pend_valid <= issue.valid;
      if (out_fire) begin
        q_head <= ~q_head;
      end
      q_count <= q_count + {1'b0, pend_valid} - {1'b0, out_fire};
    end
  end

  // Hold the issued tag until the RAM data lands
  always_ff @(posedge clk) begin
    pend_status  <= issue.status;
    pend_last    <= issue.last;
    pend_use_ram <= issue.use_ram;
    if (pend_valid) begin
      q_mem[q_tail] <= pend_result;
    end
  end

endmodule
